// File: rtl/dscr_pkg.sv
// Shared types and constants for the dual serial channel register block.
// No dependencies; every other file but dscr_if imports this package.
`default_nettype none

package dscr_pkg;

  // Raw opcode encodings of the input item
  localparam logic [2:0] OPC_READ   = 3'd0;
  localparam logic [2:0] OPC_WRITE  = 3'd1;
  localparam logic [2:0] OPC_ARRIVE = 3'd2;
  localparam logic [2:0] OPC_SLOT   = 3'd3;
  localparam logic [2:0] OPC_ACK    = 3'd4;

  // Decoded operation handed from controller to datapath
  typedef enum logic [2:0] {
    OP_READ,
    OP_WRITE,
    OP_ARRIVE,
    OP_SLOT,
    OP_ACK,
    OP_NOP
  } op_e;

  typedef enum logic {
    OUT_EMPTY,
    OUT_FULL
  } ostate_e;

  // Control register pointer
  localparam int unsigned REG_PTR_W = 3;
  localparam logic [REG_PTR_W-1:0] REG_CMD  = 3'd0;
  localparam logic [REG_PTR_W-1:0] REG_RIE  = 3'd1;
  localparam logic [REG_PTR_W-1:0] REG_VEC  = 3'd2;
  localparam logic [REG_PTR_W-1:0] REG_RXEN = 3'd3;
  localparam logic [REG_PTR_W-1:0] REG_TXEN = 3'd5;

  // Register 0 commands, data[5:3]
  localparam logic [2:0] CMD_CLR_PEND = 3'd2;
  localparam logic [2:0] CMD_CH_RESET = 3'd3;

  // Register 1 receive interrupt field, data[4:3]
  localparam logic [1:0] RIE_OFF = 2'd0;
  localparam logic [1:0] RIE_ON  = 2'd3;

  // Byte returned on an empty data read or a high status pointer
  localparam logic [7:0] READ_FILL = 8'h55;

  typedef struct packed {
    logic exec;
    op_e  op;
  } cmd_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       rx_accepted;
    logic       irq_request;
    logic [7:0] irq_vector;
    logic       irq_pending;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/dscr_if.sv
// Valid/ready channel interfaces for the input item and the result beat.
// Standalone; used by the top level, the checker and the testbench.
`default_nettype none

interface dscr_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [1:0] bus_address;
  logic       channel_select;
  logic [7:0] data;

  modport source (output valid, opcode, bus_address, channel_select, data, input ready);
  modport sink (input valid, opcode, bus_address, channel_select, data, output ready);
endinterface

interface dscr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [7:0] tx_byte;
  logic       tx_valid;
  logic       rx_accepted;
  logic       irq_request;
  logic [7:0] irq_vector;
  logic       irq_pending;

  modport source (output valid, read_data, tx_byte, tx_valid, rx_accepted, irq_request,
                  irq_vector, irq_pending, input ready);
  modport sink (input valid, read_data, tx_byte, tx_valid, rx_accepted, irq_request,
                irq_vector, irq_pending, output ready);
endinterface

`default_nettype wire

// File: rtl/dscr_ctrl.sv
// Controller: decodes the opcode, issues one execute command per beat and
// tracks occupancy of the result register. Depends on dscr_pkg.
`default_nettype none

module dscr_ctrl
  import dscr_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic [2:0] opcode_i,
  input  wire logic       out_ready_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  output cmd_t            cmd_o
);

  ostate_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= OUT_EMPTY;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    out_valid_o = (state_q == OUT_FULL);
    // Take a new beat when the result slot is free or drains this cycle
    in_ready_o  = (state_q == OUT_EMPTY) || out_ready_i;
    cmd_o.exec  = in_valid_i && in_ready_o;
    unique case (opcode_i)
      OPC_READ:   cmd_o.op = OP_READ;
      OPC_WRITE:  cmd_o.op = OP_WRITE;
      OPC_ARRIVE: cmd_o.op = OP_ARRIVE;
      OPC_SLOT:   cmd_o.op = OP_SLOT;
      OPC_ACK:    cmd_o.op = OP_ACK;
      default:    cmd_o.op = OP_NOP;
    endcase
    state_d = state_q;
    unique case (state_q)
      OUT_EMPTY: begin
        if (cmd_o.exec) state_d = OUT_FULL;
      end
      OUT_FULL: begin
        if (out_ready_i && !cmd_o.exec) state_d = OUT_EMPTY;
      end
      default: state_d = OUT_EMPTY;
    endcase
  end

  // A new result never lands on one that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |-> (state_q == OUT_EMPTY || out_ready_i))
    else $error("result overwritten before taken");

  // After an execute the result register is occupied
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> out_valid_o)
    else $error("result lost after execute");

endmodule

`default_nettype wire

// File: rtl/dscr_datapath.sv
// Datapath: per-channel FIFOs, control registers, shared vector and
// pending flag, and the result register. Depends on dscr_pkg.
`default_nettype none

module dscr_datapath
  import dscr_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 3
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cmd_t       cmd_i,
  input  wire logic [1:0] bus_address_i,
  input  wire logic       channel_select_i,
  input  wire logic [7:0] data_i,
  output res_t            res_o
);

  localparam int unsigned PtrW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned SumW = CntW + 1;
  localparam logic [CntW-1:0] CntFull = CntW'(FIFO_DEPTH);
  localparam logic [PtrW-1:0] HeadLast = PtrW'(FIFO_DEPTH - 1);
  localparam logic [SumW-1:0] SumWrap = SumW'(FIFO_DEPTH);

  logic [7:0] rx_mem [2][FIFO_DEPTH];
  logic [7:0] tx_mem [2][FIFO_DEPTH];

  logic [PtrW-1:0]      rx_head_q [2], rx_head_d [2];
  logic [CntW-1:0]      rx_cnt_q  [2], rx_cnt_d  [2];
  logic [PtrW-1:0]      tx_head_q [2], tx_head_d [2];
  logic [CntW-1:0]      tx_cnt_q  [2], tx_cnt_d  [2];
  logic [REG_PTR_W-1:0] ptr_q     [2], ptr_d     [2];
  logic [1:0]           char_av_q, char_av_d;
  logic [1:0]           rx_en_q, rx_en_d;
  logic [1:0]           tx_en_q, tx_en_d;
  logic [1:0]           rie_q, rie_d;
  logic [7:0]           vector_q, vector_d;
  logic                 pending_q, pending_d;
  res_t                 res_q, res_d;

  logic            ch;
  logic            is_ctrl;
  logic [SumW-1:0] rx_sum, tx_sum;
  logic [PtrW-1:0] rx_slot, tx_slot;
  logic            rx_we, tx_we;

  always_comb begin
    rx_head_d = rx_head_q;
    rx_cnt_d  = rx_cnt_q;
    tx_head_d = tx_head_q;
    tx_cnt_d  = tx_cnt_q;
    ptr_d     = ptr_q;
    char_av_d = char_av_q;
    rx_en_d   = rx_en_q;
    tx_en_d   = tx_en_q;
    rie_d     = rie_q;
    vector_d  = vector_q;
    pending_d = pending_q;
    rx_we     = 1'b0;
    tx_we     = 1'b0;
    res_d     = '0;

    ch      = (cmd_i.op == OP_ARRIVE || cmd_i.op == OP_SLOT) ? channel_select_i
                                                              : bus_address_i[1];
    is_ctrl = bus_address_i[0];

    // Tail slot = head + count, wrapped once
    rx_sum = SumW'(rx_head_q[ch]) + SumW'(rx_cnt_q[ch]);
    if (rx_sum >= SumWrap) rx_sum = rx_sum - SumWrap;
    rx_slot = rx_sum[PtrW-1:0];
    tx_sum = SumW'(tx_head_q[ch]) + SumW'(tx_cnt_q[ch]);
    if (tx_sum >= SumWrap) tx_sum = tx_sum - SumWrap;
    tx_slot = tx_sum[PtrW-1:0];

    if (cmd_i.exec) begin
      unique case (cmd_i.op)
        OP_READ: begin
          if (is_ctrl) begin
            if (ptr_q[ch] == REG_CMD) begin
              res_d.read_data = {7'd0, char_av_q[ch]};
            end else if (ptr_q[ch] == REG_RIE || ptr_q[ch] == REG_VEC) begin
              res_d.read_data = 8'd0;
            end else begin
              res_d.read_data = READ_FILL;
            end
          end else if (rx_cnt_q[ch] == '0) begin
            res_d.read_data = READ_FILL;
          end else begin
            res_d.read_data = rx_mem[ch][rx_head_q[ch]];
            rx_head_d[ch] = (rx_head_q[ch] == HeadLast) ? '0 : rx_head_q[ch] + 1'b1;
            rx_cnt_d[ch]  = rx_cnt_q[ch] - 1'b1;
            if (rx_cnt_q[ch] == CntW'(1)) char_av_d[ch] = 1'b0;
          end
        end
        OP_WRITE: begin
          if (is_ctrl) begin
            case (ptr_q[ch])
              REG_CMD: begin
                if (data_i[5:3] == CMD_CLR_PEND) begin
                  pending_d = 1'b0;
                end else if (data_i[5:3] == CMD_CH_RESET) begin
                  rx_head_d[ch] = '0;
                  rx_cnt_d[ch]  = '0;
                  tx_head_d[ch] = '0;
                  tx_cnt_d[ch]  = '0;
                  char_av_d[ch] = 1'b0;
                  rx_en_d[ch]   = 1'b0;
                  tx_en_d[ch]   = 1'b0;
                  rie_d[ch]     = 1'b0;
                end
              end
              REG_RIE: begin
                if (data_i[4:3] == RIE_OFF) rie_d[ch] = 1'b0;
                else if (data_i[4:3] == RIE_ON) rie_d[ch] = 1'b1;
              end
              REG_VEC:  vector_d = data_i;
              REG_RXEN: rx_en_d[ch] = data_i[0];
              REG_TXEN: tx_en_d[ch] = data_i[3];
              default: ;
            endcase
            // Pointer 0 loads the next pointer; any other register returns to 0
            ptr_d[ch] = (ptr_q[ch] == REG_CMD) ? data_i[2:0] : REG_CMD;
          end else if (tx_cnt_q[ch] != CntFull) begin
            tx_we        = 1'b1;
            tx_cnt_d[ch] = tx_cnt_q[ch] + 1'b1;
          end
        end
        OP_ARRIVE: begin
          if (rx_cnt_q[ch] != CntFull) begin
            res_d.rx_accepted = 1'b1;
            if (rx_en_q[ch]) begin
              rx_we         = 1'b1;
              rx_cnt_d[ch]  = rx_cnt_q[ch] + 1'b1;
              char_av_d[ch] = 1'b1;
              if (rie_q[ch]) begin
                res_d.irq_request = !pending_q;
                pending_d = 1'b1;
              end
            end
          end
        end
        OP_SLOT: begin
          if (tx_en_q[ch] && tx_cnt_q[ch] != '0) begin
            res_d.tx_byte  = tx_mem[ch][tx_head_q[ch]];
            res_d.tx_valid = 1'b1;
            tx_head_d[ch]  = (tx_head_q[ch] == HeadLast) ? '0 : tx_head_q[ch] + 1'b1;
            tx_cnt_d[ch]   = tx_cnt_q[ch] - 1'b1;
          end
        end
        OP_ACK:  pending_d = 1'b0;
        OP_NOP:  ;
        default: ;
      endcase
    end

    res_d.irq_vector  = vector_d;
    res_d.irq_pending = pending_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_head_q <= '{default: '0};
      rx_cnt_q  <= '{default: '0};
      tx_head_q <= '{default: '0};
      tx_cnt_q  <= '{default: '0};
      ptr_q     <= '{default: '0};
      char_av_q <= '0;
      rx_en_q   <= '0;
      tx_en_q   <= '0;
      rie_q     <= '0;
      vector_q  <= '0;
      pending_q <= 1'b0;
    end else begin
      rx_head_q <= rx_head_d;
      rx_cnt_q  <= rx_cnt_d;
      tx_head_q <= tx_head_d;
      tx_cnt_q  <= tx_cnt_d;
      ptr_q     <= ptr_d;
      char_av_q <= char_av_d;
      rx_en_q   <= rx_en_d;
      tx_en_q   <= tx_en_d;
      rie_q     <= rie_d;
      vector_q  <= vector_d;
      pending_q <= pending_d;
    end
  end

  // Result register holds payload only
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) res_q <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (rx_we) rx_mem[ch][rx_slot] <= data_i;
    if (tx_we) tx_mem[ch][tx_slot] <= data_i;
  end

  assign res_o = res_q;

  for (genvar c = 0; c < 2; c++) begin : g_chk
    // Character-available flag tracks a non-empty receive FIFO
    assert property (@(posedge clk_i) disable iff (!rst_ni)
      char_av_q[c] == (rx_cnt_q[c] != '0))
      else $error("char available out of step with receive count");

    assert property (@(posedge clk_i) disable iff (!rst_ni)
      rx_cnt_q[c] <= CntFull && tx_cnt_q[c] <= CntFull)
      else $error("FIFO count beyond depth");
  end

  // A new request always leaves the pending flag set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && res_d.irq_request |=> pending_q && res_q.irq_pending)
    else $error("interrupt request without pending flag");

endmodule

`default_nettype wire

// File: rtl/dual_serial_channel_registers.sv
// Top level of the dual serial channel register block.
// Depends on dscr_pkg, dscr_if, dscr_ctrl and dscr_datapath.
`default_nettype none

//  channel  dir  handshake          payload
//  in_i     in   valid/ready        opcode, bus_address, channel_select, data
//  out_o    out  valid/ready        read_data, tx_byte, tx_valid, rx_accepted,
//                                   irq_request, irq_vector, irq_pending
//
//  Every beat executes in the cycle it is accepted: one beat per cycle while the
//  output does not stall, the result showing in the output register in the next cycle.
//  The single output register sets the rate: a new beat is taken while the
//  previous result drains in the same cycle, and held off while it stalls.
//  Reset clears pointers, counts, enables, vector and pending flag at once;
//  FIFO storage is not cleared and needs no clearing pass.

module dual_serial_channel_registers
  import dscr_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 3
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  dscr_in_if.sink    in_i,
  dscr_out_if.source out_o
);

  cmd_t cmd;
  res_t res;
  logic in_ready;
  logic out_valid;

  // Controller: accept beats and track the result register
  dscr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .opcode_i    (in_i.opcode),
    .out_ready_i (out_o.ready),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .cmd_o       (cmd)
  );

  // Datapath: FIFOs, channel registers and result register
  dscr_datapath #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .bus_address_i    (in_i.bus_address),
    .channel_select_i (in_i.channel_select),
    .data_i           (in_i.data),
    .res_o            (res)
  );

  assign in_i.ready        = in_ready;
  assign out_o.valid       = out_valid;
  assign out_o.read_data   = res.read_data;
  assign out_o.tx_byte     = res.tx_byte;
  assign out_o.tx_valid    = res.tx_valid;
  assign out_o.rx_accepted = res.rx_accepted;
  assign out_o.irq_request = res.irq_request;
  assign out_o.irq_vector  = res.irq_vector;
  assign out_o.irq_pending = res.irq_pending;

endmodule

`default_nettype wire

// File: tb/sv/dual_serial_channel_registers_checker.sv
`timescale 1ns / 100ps
// Result checker for the dual serial channel register block.
// Watches both handshake channels and predicts every result beat in step.
// Depends on dscr_pkg and the dscr_in_if / dscr_out_if interfaces.

module dual_serial_channel_registers_checker
  import dscr_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 3
) (
  input  logic clk_i,
  input  logic rst_ni,
  dscr_in_if   beat_in_i,
  dscr_out_if  beat_out_i,
  output int   mismatches_o,
  output int   backlog_o
);

  localparam int          REPORT_MAX      = 10;
  localparam logic [2:0]  STATUS_FILL_PTR = 3'd3;

  logic [7:0]  rx_fifo [2][FIFO_DEPTH];
  logic [7:0]  tx_fifo [2][FIFO_DEPTH];
  int unsigned rx_head [2];
  int unsigned rx_fill [2];
  int unsigned tx_head [2];
  int unsigned tx_fill [2];
  logic [2:0]  reg_ptr [2];
  logic        char_av [2];
  logic        rx_on [2];
  logic        tx_on [2];
  logic        rx_irq_on [2];
  logic [7:0]  vector_q;
  logic        irq_flag;

  res_t port_results_due [$];
  int   errs;

  function automatic int unsigned ring_add(input int unsigned head, input int unsigned offs);
    int unsigned s;
    s = head + offs;
    if (s >= FIFO_DEPTH) s -= FIFO_DEPTH;
    return s;
  endfunction

  function automatic void clear_channel(input int ch);
    reg_ptr[ch]   = REG_CMD;
    rx_head[ch]   = 0;
    rx_fill[ch]   = 0;
    tx_head[ch]   = 0;
    tx_fill[ch]   = 0;
    char_av[ch]   = 1'b0;
    rx_on[ch]     = 1'b0;
    tx_on[ch]     = 1'b0;
    rx_irq_on[ch] = 1'b0;
  endfunction

  // Advance the shadow state by one beat and return what the block must answer.
  function automatic res_t apply_bus_event(input logic [2:0] opc, input logic [1:0] addr,
                                           input logic sel, input logic [7:0] d);
    res_t       r;
    int         ch;
    int         s;
    logic [2:0] p;
    logic [2:0] nxt;
    r  = '0;
    ch = addr[1];
    s  = sel;
    case (opc)
      OPC_READ: begin
        if (addr[0]) begin
          p = reg_ptr[ch];
          if (p >= STATUS_FILL_PTR) r.read_data = READ_FILL;
          else if (p == REG_CMD) r.read_data = {7'd0, char_av[ch]};
        end else if (rx_fill[ch] == 0) begin
          r.read_data = READ_FILL;
        end else begin
          r.read_data = rx_fifo[ch][rx_head[ch]];
          rx_head[ch] = ring_add(rx_head[ch], 1);
          rx_fill[ch]--;
          if (rx_fill[ch] == 0) char_av[ch] = 1'b0;
        end
      end
      OPC_WRITE: begin
        if (addr[0]) begin
          p   = reg_ptr[ch];
          nxt = (p == REG_CMD) ? d[2:0] : REG_CMD;
          case (p)
            REG_CMD: begin
              if (d[5:3] == CMD_CLR_PEND) irq_flag = 1'b0;
              else if (d[5:3] == CMD_CH_RESET) clear_channel(ch);
            end
            REG_RIE: begin
              if (d[4:3] == RIE_OFF) rx_irq_on[ch] = 1'b0;
              else if (d[4:3] == RIE_ON) rx_irq_on[ch] = 1'b1;
            end
            REG_VEC:  vector_q = d;
            REG_RXEN: rx_on[ch] = d[0];
            REG_TXEN: tx_on[ch] = d[3];
            default: ;
          endcase
          reg_ptr[ch] = nxt;
        end else if (tx_fill[ch] < FIFO_DEPTH) begin
          tx_fifo[ch][ring_add(tx_head[ch], tx_fill[ch])] = d;
          tx_fill[ch]++;
        end
      end
      OPC_ARRIVE: begin
        if (rx_fill[s] < FIFO_DEPTH) begin
          r.rx_accepted = 1'b1;
          // a disabled receiver still takes the byte, then drops it
          if (rx_on[s]) begin
            rx_fifo[s][ring_add(rx_head[s], rx_fill[s])] = d;
            rx_fill[s]++;
            char_av[s] = 1'b1;
            if (rx_irq_on[s]) begin
              r.irq_request = !irq_flag;
              irq_flag      = 1'b1;
            end
          end
        end
      end
      OPC_SLOT: begin
        if (tx_on[s] && tx_fill[s] != 0) begin
          r.tx_byte  = tx_fifo[s][tx_head[s]];
          r.tx_valid = 1'b1;
          tx_head[s] = ring_add(tx_head[s], 1);
          tx_fill[s]--;
        end
      end
      OPC_ACK: irq_flag = 1'b0;
      default: ;
    endcase
    r.irq_vector  = vector_q;
    r.irq_pending = irq_flag;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    res_t got;
    logic bad;
    if (!rst_ni) begin
      clear_channel(0);
      clear_channel(1);
      vector_q = 8'd0;
      irq_flag = 1'b0;
      port_results_due.delete();
      errs = 0;
      mismatches_o <= 0;
      backlog_o    <= 0;
    end else begin
      // queue first, so a result is always matched against the oldest beat
      if (beat_in_i.valid && beat_in_i.ready)
        port_results_due.push_back(apply_bus_event(beat_in_i.opcode, beat_in_i.bus_address,
                                                   beat_in_i.channel_select, beat_in_i.data));
      if (beat_out_i.valid && beat_out_i.ready) begin
        got.read_data   = beat_out_i.read_data;
        got.tx_byte     = beat_out_i.tx_byte;
        got.tx_valid    = beat_out_i.tx_valid;
        got.rx_accepted = beat_out_i.rx_accepted;
        got.irq_request = beat_out_i.irq_request;
        got.irq_vector  = beat_out_i.irq_vector;
        got.irq_pending = beat_out_i.irq_pending;
        if (port_results_due.size() == 0) begin
          errs++;
          if (errs <= REPORT_MAX)
            $display("[%0t] result beat with nothing outstanding: rd=%02h", $time,
                     got.read_data);
        end else begin
          want = port_results_due.pop_front();
          bad  = (got.read_data !== want.read_data) || (got.tx_byte !== want.tx_byte) ||
                 (got.tx_valid !== want.tx_valid) || (got.rx_accepted !== want.rx_accepted) ||
                 (got.irq_request !== want.irq_request) ||
                 (got.irq_vector !== want.irq_vector) ||
                 (got.irq_pending !== want.irq_pending);
          if (bad) begin
            errs++;
            if (errs <= REPORT_MAX) begin
              $display("[%0t] mismatch exp: rd=%02h tx=%02h txv=%0b rxa=%0b irq=%0b vec=%02h pend=%0b",
                       $time, want.read_data, want.tx_byte, want.tx_valid, want.rx_accepted,
                       want.irq_request, want.irq_vector, want.irq_pending);
              $display("         act: rd=%02h tx=%02h txv=%0b rxa=%0b irq=%0b vec=%02h pend=%0b",
                       got.read_data, got.tx_byte, got.tx_valid, got.rx_accepted,
                       got.irq_request, got.irq_vector, got.irq_pending);
            end
          end
        end
      end
      mismatches_o <= errs;
      backlog_o    <= port_results_due.size();
    end
  end

endmodule

// File: tb/sv/dual_serial_channel_registers_tb.sv
`timescale 1ns / 100ps
// Top of the dual serial channel register testbench: clock, reset, stimulus,
// receiver stalls and verdict. Depends on dscr_pkg, the channel interfaces,
// the block itself and dual_serial_channel_registers_checker.

module dual_serial_channel_registers_tb;
  import dscr_pkg::*;

  localparam int unsigned FIFO_DEPTH   = 3;
  localparam int          RANDOM_BEATS = 1400;
  localparam int          LIMIT_CYCLES = 300000;

  // Bus ports: channel in bit 1, control in bit 0
  localparam logic [1:0] PORT_A_DATA = 2'd0;
  localparam logic [1:0] PORT_A_CTRL = 2'd1;
  localparam logic [1:0] PORT_B_DATA = 2'd2;
  localparam logic [1:0] PORT_B_CTRL = 2'd3;
  localparam logic       CH_A        = 1'b0;
  localparam logic       CH_B        = 1'b1;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_SPARSE,
    RDY_PERIODIC
  } rdy_mode_e;

  logic clk_i;
  logic rst_ni = 1'b0;

  dscr_in_if  in_ch ();
  dscr_out_if out_ch ();

  int mismatches;
  int backlog;

  // Stimulus bookkeeping; the pointer copy only keeps register setups well formed
  int         burst_left    = 0;
  int         beats_sent    = 0;
  int         hold_requests = 0;
  logic [2:0] ptr_shadow [2] = '{REG_CMD, REG_CMD};

  dual_serial_channel_registers #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  dual_serial_channel_registers_checker #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_in_i   (in_ch),
    .beat_out_i  (out_ch),
    .mismatches_o(mismatches),
    .backlog_o   (backlog)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: end the run if the handshakes ever stop making progress.
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // Offer one beat and hold it until the block takes it. Open a new burst,
  // with a random gap in front, whenever the current one is used up.
  task automatic push_beat(input logic [2:0] opc, input logic [1:0] addr,
                           input logic sel, input logic [7:0] d);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_ch.valid          <= 1'b1;
    in_ch.opcode         <= opc;
    in_ch.bus_address    <= addr;
    in_ch.channel_select <= sel;
    in_ch.data           <= d;
    do @(posedge clk_i); while (!in_ch.ready);
    // track the control pointer the same way the block moves it
    if (opc == OPC_WRITE && addr[0])
      ptr_shadow[addr[1]] = (ptr_shadow[addr[1]] == REG_CMD) ? d[2:0] : REG_CMD;
    if (opc <= OPC_ACK) beats_sent++;
  endtask

  // Stop offering and wait until every predicted result has drained.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (backlog != 0);
    burst_left = 0;
  endtask

  // Command bits for a pointer write, kept clear of the channel reset.
  function automatic logic [4:0] pointer_hi_bits();
    logic [4:0] hi;
    hi = 5'($urandom);
    if (hi[2:0] == CMD_CH_RESET) hi[2:0] = CMD_CLR_PEND;
    return hi;
  endfunction

  // Write one control register. A pointer left nonzero would steer the
  // pointer write elsewhere, so spend it first with random content.
  task automatic write_reg(input logic ch, input logic [2:0] regn, input logic [7:0] val);
    if (ptr_shadow[ch] != REG_CMD)
      push_beat(OPC_WRITE, {ch, 1'b1}, 1'($urandom), 8'($urandom));
    if (regn != REG_CMD)
      push_beat(OPC_WRITE, {ch, 1'b1}, 1'($urandom), {pointer_hi_bits(), regn});
    push_beat(OPC_WRITE, {ch, 1'b1}, 1'($urandom), val);
  endtask

  // One well-formed random sequence, or a beat of noise now and then.
  task automatic random_scenario();
    int         kind;
    int         n;
    logic       ch;
    logic [1:0] rie;
    kind = $urandom_range(0, 99);
    ch   = 1'($urandom);
    if (kind < 35) begin
      // serial traffic on one channel: arrivals, slots, data reads and writes
      n = $urandom_range(1, 10);
      repeat (n) begin
        case ($urandom_range(0, 3))
          0: push_beat(OPC_ARRIVE, 2'($urandom), ch, 8'($urandom));
          1: push_beat(OPC_READ, {ch, 1'b0}, 1'($urandom), 8'($urandom));
          2: push_beat(OPC_WRITE, {ch, 1'b0}, 1'($urandom), 8'($urandom));
          default: push_beat(OPC_SLOT, 2'($urandom), ch, 8'($urandom));
        endcase
      end
    end else if (kind < 60) begin
      // register setup, biased toward enabling the channel
      case ($urandom_range(0, 9))
        0, 1: begin
          rie = ($urandom_range(0, 2) == 0) ? 2'($urandom) : RIE_ON;
          write_reg(ch, REG_RIE, {3'($urandom), rie, 3'($urandom)});
        end
        2: write_reg(ch, REG_VEC, 8'($urandom));
        3, 4, 5: write_reg(ch, REG_RXEN, {7'($urandom), 1'($urandom_range(0, 3) != 0)});
        6, 7: write_reg(ch, REG_TXEN,
                        {4'($urandom), 1'($urandom_range(0, 3) != 0), 3'($urandom)});
        default: write_reg(ch, 3'($urandom), 8'($urandom));
      endcase
    end else if (kind < 72) begin
      // status read, often after moving the pointer
      if ($urandom_range(0, 1) == 1 && ptr_shadow[ch] == REG_CMD)
        push_beat(OPC_WRITE, {ch, 1'b1}, 1'($urandom), {pointer_hi_bits(), 3'($urandom)});
      push_beat(OPC_READ, {ch, 1'b1}, 1'($urandom), 8'($urandom));
    end else if (kind < 82) begin
      if ($urandom_range(0, 1) == 1)
        push_beat(OPC_ACK, 2'($urandom), 1'($urandom), 8'($urandom));
      else
        write_reg(ch, REG_CMD, {2'($urandom), CMD_CLR_PEND, 3'b000});
    end else if (kind < 85) begin
      write_reg(ch, REG_CMD, {2'($urandom), CMD_CH_RESET, 3'($urandom)});
    end else begin
      push_beat(3'($urandom), 2'($urandom), 1'($urandom), 8'($urandom));
    end
  endtask

  // Receiver: stall on a pattern drawn anew whenever the current one runs out, and
  // serve each long hold-off request by counting the stretch here.
  initial begin
    int        mode_left;
    int        hold_left;
    int        holds_done;
    int        tick;
    rdy_mode_e mode;
    mode_left  = 0;
    hold_left  = 0;
    holds_done = 0;
    tick       = 0;
    mode       = RDY_ALWAYS;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      tick++;
      if (hold_left == 0 && holds_done != hold_requests) begin
        holds_done++;
        hold_left = $urandom_range(60, 120);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = rdy_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(40, 200);
        end
        mode_left--;
        case (mode)
          RDY_ALWAYS: out_ch.ready <= 1'b1;
          RDY_COIN:   out_ch.ready <= 1'($urandom);
          RDY_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default:    out_ch.ready <= (tick % 3 == 0);
        endcase
      end
    end
  end

  // Stimulus and verdict
  initial begin
    int random_goal;
    int next_drain;
    int next_hold;
    in_ch.valid          <= 1'b0;
    in_ch.opcode         <= OPC_READ;
    in_ch.bus_address    <= PORT_A_DATA;
    in_ch.channel_select <= CH_A;
    in_ch.data           <= 8'd0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty read, channel A receive path with interrupts
    push_beat(OPC_READ, PORT_A_DATA, CH_B, 8'h00);
    push_beat(OPC_WRITE, PORT_A_CTRL, CH_A, {5'd0, REG_RXEN});
    push_beat(OPC_WRITE, PORT_A_CTRL, CH_A, 8'h01);
    push_beat(OPC_WRITE, PORT_A_CTRL, CH_A, {5'd0, REG_RIE});
    push_beat(OPC_WRITE, PORT_A_CTRL, CH_A, {3'd0, RIE_ON, 3'd0});
    push_beat(OPC_WRITE, PORT_A_CTRL, CH_A, {5'd0, REG_VEC});
    push_beat(OPC_WRITE, PORT_A_CTRL, CH_A, 8'hFF);
    // first arrival raises the request, the next ones find it pending
    push_beat(OPC_ARRIVE, PORT_A_DATA, CH_A, 8'h00);
    push_beat(OPC_ARRIVE, PORT_B_CTRL, CH_A, 8'hFF);
    push_beat(OPC_ARRIVE, PORT_A_DATA, CH_A, 8'hA5);
    // full receive FIFO refuses the byte
    push_beat(OPC_ARRIVE, PORT_A_DATA, CH_A, 8'h5A);
    push_beat(OPC_READ, PORT_A_CTRL, CH_A, 8'h00);
    // drain it; the last pop clears the character-available bit
    repeat (3) push_beat(OPC_READ, PORT_A_DATA, CH_A, 8'h00);
    push_beat(OPC_READ, PORT_A_CTRL, CH_B, 8'h00);
    push_beat(OPC_WRITE, PORT_A_CTRL, CH_A, {2'd0, CMD_CLR_PEND, 3'd0});
    // channel B: receiver off takes and drops, transmit FIFO overflow drops
    push_beat(OPC_ARRIVE, PORT_A_DATA, CH_B, 8'h33);
    push_beat(OPC_WRITE, PORT_B_DATA, CH_A, 8'hFF);
    push_beat(OPC_WRITE, PORT_B_DATA, CH_B, 8'h00);
    push_beat(OPC_WRITE, PORT_B_DATA, CH_A, 8'h11);
    push_beat(OPC_WRITE, PORT_B_DATA, CH_B, 8'h22);
    push_beat(OPC_SLOT, PORT_A_DATA, CH_B, 8'h00);
    push_beat(OPC_WRITE, PORT_B_CTRL, CH_A, {5'd0, REG_TXEN});
    push_beat(OPC_WRITE, PORT_B_CTRL, CH_A, 8'h08);
    push_beat(OPC_SLOT, PORT_B_DATA, CH_B, 8'h00);
    // channel reset that also leaves the pointer at 3, then ack and a spare opcode
    push_beat(OPC_WRITE, PORT_A_CTRL, CH_A, {2'd0, CMD_CH_RESET, REG_RXEN});
    push_beat(OPC_READ, PORT_A_CTRL, CH_A, 8'h00);
    push_beat(OPC_ACK, PORT_B_CTRL, CH_B, 8'hFF);
    push_beat(3'($urandom_range(OPC_ACK + 1, 7)), PORT_B_CTRL, CH_B, 8'hFF);
    drain_results();

    // Random: request long receiver holds and full drains along the way
    random_goal = beats_sent + RANDOM_BEATS;
    next_hold   = beats_sent + 200;
    next_drain  = beats_sent + 350;
    while (beats_sent < random_goal) begin
      if (beats_sent >= next_hold) begin
        hold_requests <= hold_requests + 1;
        next_hold += 450;
      end
      if (beats_sent >= next_drain) begin
        drain_results();
        next_drain += 350;
      end
      random_scenario();
    end

    drain_results();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0 && backlog == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// File: dual_serial_channel_registers.f
rtl/dscr_pkg.sv
rtl/dscr_if.sv
rtl/dscr_ctrl.sv
rtl/dscr_datapath.sv
rtl/dual_serial_channel_registers.sv
tb/sv/dual_serial_channel_registers_checker.sv
tb/sv/dual_serial_channel_registers_tb.sv
